// ----- src/i2c_master_transfer_sequencer_top_macros.svh -----
// Assertion macros for the I2C master transfer sequencer
`ifndef I2C_MASTER_TRANSFER_SEQUENCER_TOP_MACROS_SVH
`define I2C_MASTER_TRANSFER_SEQUENCER_TOP_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define I2CMS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define I2CMS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/i2cms_pkg.sv -----
// Shared constants, operation codes and types of the I2C master transfer sequencer
package i2cms_pkg;

  localparam int CMD_DEPTH  = 8;
  localparam int DATA_DEPTH = 8;
  localparam int CMD_AW     = $clog2(CMD_DEPTH);
  localparam int DATA_AW    = $clog2(DATA_DEPTH);
  localparam int CNT_W      = 4;

  typedef enum logic [2:0] {
    OP_LOAD_CMD = 3'd0,
    OP_LOAD_TX  = 3'd1,
    OP_START_WR = 3'd2,
    OP_START_RD = 3'd3,
    OP_IRQ      = 3'd4
  } op_t;

  typedef struct packed {
    logic               cmd_we;
    logic               tx_we;
    logic [2:0]         waddr;
    logic [7:0]         wdata;
    logic [CMD_AW-1:0]  cmd_raddr;
    logic [DATA_AW-1:0] tx_raddr;
  } st_req_t;

  typedef struct packed {
    logic       accepted;
    logic       write_strobe;
    logic [7:0] write_value;
    logic       repeat_start;
    logic       read_strobe;
    logic       rx_store;
    logic [2:0] rx_position;
    logic [7:0] rx_value;
    logic       ack_enable;
    logic       master_mode;
    logic       transmit_dir;
    logic       busy_res;
  } res_t;

endpackage

// ----- src/i2cms_store.sv -----
// Command and transmit byte stores
module i2cms_store (
  input  logic                        clk,
  input  i2cms_pkg::st_req_t          req,
  output logic [7:0]                  cmd_rdata,
  output logic [7:0]                  cmd_rdata0,
  output logic [7:0]                  tx_rdata,
  output logic [7:0]                  tx_rdata0
);

  logic [7:0]                    cmd_mem_r [i2cms_pkg::CMD_DEPTH];
  logic [7:0]                    tx_mem_r  [i2cms_pkg::DATA_DEPTH];
  logic [7:0]                    cmd_rd_r;
  logic [7:0]                    cmd_rd0_r;
  logic [7:0]                    tx_rd_r;
  logic [7:0]                    tx_rd0_r;
  logic [i2cms_pkg::CMD_AW-1:0]  cmd_waddr;
  logic [i2cms_pkg::DATA_AW-1:0] tx_waddr;

  assign cmd_waddr = req.waddr[i2cms_pkg::CMD_AW-1:0];
  assign tx_waddr  = req.waddr[i2cms_pkg::DATA_AW-1:0];

  // reads are registered ahead at the positions the next beat uses
  always_ff @(posedge clk) begin
    if (req.cmd_we) begin
      cmd_mem_r[cmd_waddr] <= req.wdata;
    end
    if (req.tx_we) begin
      tx_mem_r[tx_waddr] <= req.wdata;
    end
    if (req.cmd_we && cmd_waddr == req.cmd_raddr) begin
      cmd_rd_r <= req.wdata;
    end else begin
      cmd_rd_r <= cmd_mem_r[req.cmd_raddr];
    end
    if (req.cmd_we && cmd_waddr == i2cms_pkg::CMD_AW'(0)) begin
      cmd_rd0_r <= req.wdata;
    end else begin
      cmd_rd0_r <= cmd_mem_r[i2cms_pkg::CMD_AW'(0)];
    end
    if (req.tx_we && tx_waddr == req.tx_raddr) begin
      tx_rd_r <= req.wdata;
    end else begin
      tx_rd_r <= tx_mem_r[req.tx_raddr];
    end
    if (req.tx_we && tx_waddr == i2cms_pkg::DATA_AW'(0)) begin
      tx_rd0_r <= req.wdata;
    end else begin
      tx_rd0_r <= tx_mem_r[i2cms_pkg::DATA_AW'(0)];
    end
  end

  assign cmd_rdata  = cmd_rd_r;
  assign cmd_rdata0 = cmd_rd0_r;
  assign tx_rdata   = tx_rd_r;
  assign tx_rdata0  = tx_rd0_r;

endmodule

// ----- src/i2cms_ctrl.sv -----
// Transfer state and per-event decision logic
module i2cms_ctrl (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            step,
  input  logic [2:0]                      operation,
  input  logic [2:0]                      load_index,
  input  logic [7:0]                      load_byte,
  input  logic [i2cms_pkg::CNT_W-1:0]     cmd_count,
  input  logic [i2cms_pkg::CNT_W-1:0]     data_count,
  input  logic                            bus_busy_flag,
  input  logic                            ack_status_flag,
  input  logic [7:0]                      bus_read_byte,
  input  logic [7:0]                      cmd_rdata,
  input  logic [7:0]                      cmd_rdata0,
  input  logic [7:0]                      tx_rdata,
  input  logic [7:0]                      tx_rdata0,
  output i2cms_pkg::st_req_t              st_req,
  output i2cms_pkg::res_t                 res
);

  logic                              busy_r, busy_nxt;
  logic                              master_r, master_nxt;
  logic                              dir_r, dir_nxt;
  logic                              overall_r, overall_nxt;
  logic                              ack_r, ack_nxt;
  logic [i2cms_pkg::CNT_W-1:0]       cmd_left_r, cmd_left_nxt;
  logic [i2cms_pkg::CNT_W-1:0]       data_left_r, data_left_nxt;
  logic [i2cms_pkg::CMD_AW-1:0]      cmd_pos_r, cmd_pos_nxt;
  logic [i2cms_pkg::DATA_AW-1:0]     data_pos_r, data_pos_nxt;

  always_comb begin
    logic                        done;
    logic [i2cms_pkg::CNT_W-1:0] left1;
    done          = 1'b0;
    left1         = '0;
    busy_nxt      = busy_r;
    master_nxt    = master_r;
    dir_nxt       = dir_r;
    overall_nxt   = overall_r;
    ack_nxt       = ack_r;
    cmd_left_nxt  = cmd_left_r;
    data_left_nxt = data_left_r;
    cmd_pos_nxt   = cmd_pos_r;
    data_pos_nxt  = data_pos_r;
    res           = '0;
    st_req.cmd_we    = 1'b0;
    st_req.tx_we     = 1'b0;
    st_req.waddr     = load_index;
    st_req.wdata     = load_byte;
    if (step) begin
      case (i2cms_pkg::op_t'(operation))
        i2cms_pkg::OP_LOAD_CMD: begin
          st_req.cmd_we = (int'(load_index) < i2cms_pkg::CMD_DEPTH);
        end
        i2cms_pkg::OP_LOAD_TX: begin
          st_req.tx_we = (int'(load_index) < i2cms_pkg::DATA_DEPTH);
        end
        i2cms_pkg::OP_START_WR, i2cms_pkg::OP_START_RD: begin
          if (!busy_r && data_count != '0 && !bus_busy_flag) begin
            res.accepted  = 1'b1;
            busy_nxt      = 1'b1;
            master_nxt    = 1'b1;
            dir_nxt       = 1'b1;
            overall_nxt   = (operation == i2cms_pkg::OP_START_WR);
            cmd_left_nxt  = cmd_count;
            data_left_nxt = data_count;
            cmd_pos_nxt   = '0;
            data_pos_nxt  = '0;
            if (cmd_count != '0) begin
              res.repeat_start = (operation == i2cms_pkg::OP_START_RD) &&
                                 (cmd_count == i2cms_pkg::CNT_W'(1));
              res.write_strobe = 1'b1;
              res.write_value  = cmd_rdata0;
              cmd_pos_nxt      = i2cms_pkg::CMD_AW'(1);
              cmd_left_nxt     = cmd_count - i2cms_pkg::CNT_W'(1);
            end else if (operation == i2cms_pkg::OP_START_WR) begin
              res.write_strobe = 1'b1;
              res.write_value  = tx_rdata0;
              data_pos_nxt     = i2cms_pkg::DATA_AW'(1);
              data_left_nxt    = data_count - i2cms_pkg::CNT_W'(1);
            end else begin
              dir_nxt         = 1'b0;
              ack_nxt         = (data_count != i2cms_pkg::CNT_W'(1));
              res.read_strobe = 1'b1;
            end
          end
        end
        i2cms_pkg::OP_IRQ: begin
          if (busy_r && master_r) begin
            if (dir_r) begin
              done = (cmd_left_r == '0) && (!overall_r || data_left_r == '0);
              if (ack_status_flag || done) begin
                if (overall_r || ack_status_flag) begin
                  master_nxt = 1'b0;
                  dir_nxt    = 1'b0;
                  busy_nxt   = 1'b0;
                end else begin
                  dir_nxt         = 1'b0;
                  ack_nxt         = (data_left_r != i2cms_pkg::CNT_W'(1));
                  res.read_strobe = 1'b1;
                  res.rx_store    = 1'b1;
                  res.rx_position = 3'(data_pos_r);
                  res.rx_value    = bus_read_byte;
                end
              end else if (cmd_left_r != '0) begin
                res.repeat_start = (cmd_left_r == i2cms_pkg::CNT_W'(1)) && !overall_r;
                res.write_strobe = 1'b1;
                res.write_value  = cmd_rdata;
                cmd_pos_nxt      = cmd_pos_r + i2cms_pkg::CMD_AW'(1);
                cmd_left_nxt     = cmd_left_r - i2cms_pkg::CNT_W'(1);
              end else begin
                res.write_strobe = 1'b1;
                res.write_value  = tx_rdata;
                data_pos_nxt     = data_pos_r + i2cms_pkg::DATA_AW'(1);
                if (data_left_r != '0) begin
                  data_left_nxt = data_left_r - i2cms_pkg::CNT_W'(1);
                end
              end
            end else begin
              ack_nxt         = (data_left_r != i2cms_pkg::CNT_W'(2));
              res.read_strobe = 1'b1;
              res.rx_store    = 1'b1;
              res.rx_position = 3'(data_pos_r);
              res.rx_value    = bus_read_byte;
              data_pos_nxt    = data_pos_r + i2cms_pkg::DATA_AW'(1);
              if (data_left_r != '0) begin
                left1 = data_left_r - i2cms_pkg::CNT_W'(1);
              end
              data_left_nxt = left1;
              if (left1 == '0) begin
                master_nxt = 1'b0;
                dir_nxt    = 1'b0;
                busy_nxt   = 1'b0;
              end
            end
          end
        end
        default: begin
        end
      endcase
    end
    st_req.cmd_raddr = cmd_pos_nxt;
    st_req.tx_raddr  = data_pos_nxt;
    res.ack_enable   = ack_nxt;
    res.master_mode  = master_nxt;
    res.transmit_dir = dir_nxt;
    res.busy_res     = busy_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      master_r    <= 1'b0;
      dir_r       <= 1'b0;
      overall_r   <= 1'b0;
      ack_r       <= 1'b1;
      cmd_left_r  <= '0;
      data_left_r <= '0;
      cmd_pos_r   <= '0;
      data_pos_r  <= '0;
    end else begin
      busy_r      <= busy_nxt;
      master_r    <= master_nxt;
      dir_r       <= dir_nxt;
      overall_r   <= overall_nxt;
      ack_r       <= ack_nxt;
      cmd_left_r  <= cmd_left_nxt;
      data_left_r <= data_left_nxt;
      cmd_pos_r   <= cmd_pos_nxt;
      data_pos_r  <= data_pos_nxt;
    end
  end

endmodule

// ----- src/i2c_master_transfer_sequencer_top.sv -----
// Top level of the I2C master transfer sequencer: input register, control, result register
//
//   channel | ports                       | handshake
//   in      | in_operation .. in_bus_read_byte | in_valid / in_stall
//   out     | out_accepted .. out_busy_res     | out_valid / out_stall
//
// One beat per cycle unless the output stalls; a beat passes the input and result registers.
// The input register feeds the control logic, which updates the transfer state and
// the byte stores and loads the result register in the same cycle.
// Store reads are registered ahead at the positions the next beat uses.
// Reset clears the transfer state; the byte stores hold garbage until loaded.
// A stalled result holds the input register; the input stalls only while both are full.
`include "i2c_master_transfer_sequencer_top_macros.svh"

module i2c_master_transfer_sequencer_top (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [2:0]                  in_operation,
  input  logic [2:0]                  in_load_index,
  input  logic [7:0]                  in_load_byte,
  input  logic [i2cms_pkg::CNT_W-1:0] in_cmd_count,
  input  logic [i2cms_pkg::CNT_W-1:0] in_data_count,
  input  logic                        in_bus_busy_flag,
  input  logic                        in_ack_status_flag,
  input  logic [7:0]                  in_bus_read_byte,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        out_accepted,
  output logic                        out_write_strobe,
  output logic [7:0]                  out_write_value,
  output logic                        out_repeat_start,
  output logic                        out_read_strobe,
  output logic                        out_rx_store,
  output logic [2:0]                  out_rx_position,
  output logic [7:0]                  out_rx_value,
  output logic                        out_ack_enable,
  output logic                        out_master_mode,
  output logic                        out_transmit_dir,
  output logic                        out_busy_res
);

  logic                        s1_valid_r;
  logic [2:0]                  s1_operation_r;
  logic [2:0]                  s1_load_index_r;
  logic [7:0]                  s1_load_byte_r;
  logic [i2cms_pkg::CNT_W-1:0] s1_cmd_count_r;
  logic [i2cms_pkg::CNT_W-1:0] s1_data_count_r;
  logic                        s1_bus_busy_r;
  logic                        s1_ack_status_r;
  logic [7:0]                  s1_read_byte_r;
  logic                        out_valid_r;
  i2cms_pkg::res_t             out_res_r;
  i2cms_pkg::res_t             res;
  i2cms_pkg::st_req_t          st_req;
  logic [7:0]                  cmd_rdata;
  logic [7:0]                  cmd_rdata0;
  logic [7:0]                  tx_rdata;
  logic [7:0]                  tx_rdata0;
  logic                        out_free;
  logic                        step;

  assign out_free = !out_valid_r || !out_stall;
  assign step     = s1_valid_r && out_free;
  assign in_stall = s1_valid_r && !out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_operation_r  <= in_operation;
      s1_load_index_r <= in_load_index;
      s1_load_byte_r  <= in_load_byte;
      s1_cmd_count_r  <= in_cmd_count;
      s1_data_count_r <= in_data_count;
      s1_bus_busy_r   <= in_bus_busy_flag;
      s1_ack_status_r <= in_ack_status_flag;
      s1_read_byte_r  <= in_bus_read_byte;
    end
  end

  i2cms_ctrl u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .step            (step),
    .operation       (s1_operation_r),
    .load_index      (s1_load_index_r),
    .load_byte       (s1_load_byte_r),
    .cmd_count       (s1_cmd_count_r),
    .data_count      (s1_data_count_r),
    .bus_busy_flag   (s1_bus_busy_r),
    .ack_status_flag (s1_ack_status_r),
    .bus_read_byte   (s1_read_byte_r),
    .cmd_rdata       (cmd_rdata),
    .cmd_rdata0      (cmd_rdata0),
    .tx_rdata        (tx_rdata),
    .tx_rdata0       (tx_rdata0),
    .st_req          (st_req),
    .res             (res)
  );

  i2cms_store u_store (
    .clk        (clk),
    .req        (st_req),
    .cmd_rdata  (cmd_rdata),
    .cmd_rdata0 (cmd_rdata0),
    .tx_rdata   (tx_rdata),
    .tx_rdata0  (tx_rdata0)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_res_r <= res;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_accepted     = out_res_r.accepted;
  assign out_write_strobe = out_res_r.write_strobe;
  assign out_write_value  = out_res_r.write_value;
  assign out_repeat_start = out_res_r.repeat_start;
  assign out_read_strobe  = out_res_r.read_strobe;
  assign out_rx_store     = out_res_r.rx_store;
  assign out_rx_position  = out_res_r.rx_position;
  assign out_rx_value     = out_res_r.rx_value;
  assign out_ack_enable   = out_res_r.ack_enable;
  assign out_master_mode  = out_res_r.master_mode;
  assign out_transmit_dir = out_res_r.transmit_dir;
  assign out_busy_res     = out_res_r.busy_res;

  `I2CMS_ASSERT_IMP(a_idle_is_slave, out_valid_r && !out_res_r.busy_res, !out_res_r.master_mode && !out_res_r.transmit_dir, "idle result shows master or transmit")
  `I2CMS_ASSERT_IMP(a_accept_busy, out_valid_r && out_res_r.accepted, out_res_r.busy_res && out_res_r.master_mode, "accepted start without busy master")
  `I2CMS_ASSERT_IMP(a_rw_exclusive, out_valid_r, !(out_res_r.write_strobe && out_res_r.read_strobe), "write and read strobe in one beat")
  `I2CMS_ASSERT_NXT(a_step_fills_out, step, out_valid_r, "stepped item lost before result register")

endmodule

// ----- tb/i2cms_transfer_checker.sv -----
// Checker for the I2C master transfer sequencer: predicts each result beat and compares it
module i2cms_transfer_checker (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic                        in_stall,
  input  logic [2:0]                  in_operation,
  input  logic [2:0]                  in_load_index,
  input  logic [7:0]                  in_load_byte,
  input  logic [i2cms_pkg::CNT_W-1:0] in_cmd_count,
  input  logic [i2cms_pkg::CNT_W-1:0] in_data_count,
  input  logic                        in_bus_busy_flag,
  input  logic                        in_ack_status_flag,
  input  logic [7:0]                  in_bus_read_byte,
  input  logic                        out_valid,
  input  logic                        out_stall,
  input  logic                        out_accepted,
  input  logic                        out_write_strobe,
  input  logic [7:0]                  out_write_value,
  input  logic                        out_repeat_start,
  input  logic                        out_read_strobe,
  input  logic                        out_rx_store,
  input  logic [2:0]                  out_rx_position,
  input  logic [7:0]                  out_rx_value,
  input  logic                        out_ack_enable,
  input  logic                        out_master_mode,
  input  logic                        out_transmit_dir,
  input  logic                        out_busy_res,
  output int                          fail_count,
  output int                          outstanding
);

  logic                          xfer_busy;
  logic                          xfer_master;
  logic                          xfer_tx_dir;
  logic                          xfer_is_write;
  logic                          ack_on;
  logic [i2cms_pkg::CNT_W-1:0]   cmd_left;
  logic [i2cms_pkg::CNT_W-1:0]   data_left;
  logic [i2cms_pkg::CMD_AW-1:0]  cmd_pos;
  logic [i2cms_pkg::DATA_AW-1:0] data_pos;
  logic [7:0]                    cmd_mem [i2cms_pkg::CMD_DEPTH];
  logic [7:0]                    tx_mem  [i2cms_pkg::DATA_DEPTH];
  i2cms_pkg::res_t               expected_results [$];
  i2cms_pkg::res_t               want;
  int                            beats_in;
  int                            beats_out;

  assign outstanding = beats_in - beats_out;

  function automatic logic [7:0] next_cmd();
    logic [7:0] v;
    v = cmd_mem[cmd_pos];
    cmd_pos = cmd_pos + i2cms_pkg::CMD_AW'(1);
    if (cmd_left != '0) cmd_left = cmd_left - i2cms_pkg::CNT_W'(1);
    return v;
  endfunction

  function automatic logic [7:0] next_tx();
    logic [7:0] v;
    v = tx_mem[data_pos];
    data_pos = data_pos + i2cms_pkg::DATA_AW'(1);
    if (data_left != '0) data_left = data_left - i2cms_pkg::CNT_W'(1);
    return v;
  endfunction

  function automatic void end_transfer();
    xfer_master = 1'b0;
    xfer_tx_dir = 1'b0;
    xfer_busy   = 1'b0;
  endfunction

  function automatic i2cms_pkg::res_t sequence_event(
    logic [2:0] op, logic [2:0] idx, logic [7:0] lbyte,
    logic [i2cms_pkg::CNT_W-1:0] cc, logic [i2cms_pkg::CNT_W-1:0] dc,
    logic bb, logic nack, logic [7:0] rbyte);
    i2cms_pkg::res_t r;
    logic done;
    r = '0;
    case (op)
      i2cms_pkg::OP_LOAD_CMD: cmd_mem[idx] = lbyte;
      i2cms_pkg::OP_LOAD_TX:  tx_mem[idx] = lbyte;
      i2cms_pkg::OP_START_WR, i2cms_pkg::OP_START_RD: begin
        if (!xfer_busy && dc != '0 && !bb) begin
          r.accepted    = 1'b1;
          xfer_busy     = 1'b1;
          xfer_master   = 1'b1;
          xfer_tx_dir   = 1'b1;
          xfer_is_write = (op == i2cms_pkg::OP_START_WR);
          cmd_left      = cc;
          data_left     = dc;
          cmd_pos       = '0;
          data_pos      = '0;
          if (cmd_left != '0) begin
            r.repeat_start = (op == i2cms_pkg::OP_START_RD) &&
                             (cmd_left == i2cms_pkg::CNT_W'(1));
            r.write_strobe = 1'b1;
            r.write_value  = next_cmd();
          end else if (op == i2cms_pkg::OP_START_WR) begin
            r.write_strobe = 1'b1;
            r.write_value  = next_tx();
          end else begin
            // read with no command bytes: dummy read right away
            xfer_tx_dir  = 1'b0;
            ack_on       = (dc != i2cms_pkg::CNT_W'(1));
            r.read_strobe = 1'b1;
          end
        end
      end
      i2cms_pkg::OP_IRQ: begin
        if (xfer_busy && xfer_master) begin
          if (xfer_tx_dir) begin
            done = (cmd_left == '0) && (!xfer_is_write || data_left == '0);
            if (nack || done) begin
              if (xfer_is_write || nack) begin
                end_transfer();
              end else begin
                xfer_tx_dir   = 1'b0;
                ack_on        = (data_left != i2cms_pkg::CNT_W'(1));
                r.read_strobe = 1'b1;
                r.rx_store    = 1'b1;
                r.rx_position = data_pos;
                r.rx_value    = rbyte;
              end
            end else if (cmd_left != '0) begin
              r.repeat_start = (cmd_left == i2cms_pkg::CNT_W'(1)) && !xfer_is_write;
              r.write_strobe = 1'b1;
              r.write_value  = next_cmd();
            end else begin
              r.write_strobe = 1'b1;
              r.write_value  = next_tx();
            end
          end else begin
            ack_on        = (data_left != i2cms_pkg::CNT_W'(2));
            r.read_strobe = 1'b1;
            r.rx_store    = 1'b1;
            r.rx_position = data_pos;
            r.rx_value    = rbyte;
            data_pos      = data_pos + i2cms_pkg::DATA_AW'(1);
            if (data_left != '0) data_left = data_left - i2cms_pkg::CNT_W'(1);
            if (data_left == '0) end_transfer();
          end
        end
      end
      default: ;
    endcase
    r.ack_enable   = ack_on;
    r.master_mode  = xfer_master;
    r.transmit_dir = xfer_tx_dir;
    r.busy_res     = xfer_busy;
    return r;
  endfunction

  task automatic check_field(input string name, input int exp_v, input int got_v);
    if (exp_v != got_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, got_v);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      xfer_busy     = 1'b0;
      xfer_master   = 1'b0;
      xfer_tx_dir   = 1'b0;
      xfer_is_write = 1'b0;
      ack_on        = 1'b1;
      cmd_left      = '0;
      data_left     = '0;
      cmd_pos       = '0;
      data_pos      = '0;
      fail_count    = 0;
      expected_results.delete();
      beats_in  <= 0;
      beats_out <= 0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_results.push_back(sequence_event(in_operation, in_load_index, in_load_byte,
                                                  in_cmd_count, in_data_count,
                                                  in_bus_busy_flag, in_ack_status_flag,
                                                  in_bus_read_byte));
        beats_in <= beats_in + 1;
      end
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          $error("result beat with no expectation pending");
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          check_field("accepted",     int'(want.accepted),     int'(out_accepted));
          check_field("write_strobe", int'(want.write_strobe), int'(out_write_strobe));
          check_field("write_value",  int'(want.write_value),  int'(out_write_value));
          check_field("repeat_start", int'(want.repeat_start), int'(out_repeat_start));
          check_field("read_strobe",  int'(want.read_strobe),  int'(out_read_strobe));
          check_field("rx_store",     int'(want.rx_store),     int'(out_rx_store));
          check_field("rx_position",  int'(want.rx_position),  int'(out_rx_position));
          check_field("rx_value",     int'(want.rx_value),     int'(out_rx_value));
          check_field("ack_enable",   int'(want.ack_enable),   int'(out_ack_enable));
          check_field("master_mode",  int'(want.master_mode),  int'(out_master_mode));
          check_field("transmit_dir", int'(want.transmit_dir), int'(out_transmit_dir));
          check_field("busy_res",     int'(want.busy_res),     int'(out_busy_res));
        end
        beats_out <= beats_out + 1;
      end
    end
  end

endmodule

// ----- tb/tb_i2c_master_transfer_sequencer_top.sv -----
// Testbench top for the I2C master transfer sequencer: stimulus, back-pressure and verdict
module tb_i2c_master_transfer_sequencer_top;

  localparam int CYCLE_LIMIT    = 200000;
  localparam int RX_HOLD_CYCLES = 64;
  localparam int TARGET_BEATS   = 450;

  typedef struct packed {
    logic [2:0]                  op;
    logic [2:0]                  idx;
    logic [7:0]                  lbyte;
    logic [i2cms_pkg::CNT_W-1:0] cc;
    logic [i2cms_pkg::CNT_W-1:0] dc;
    logic                        bb;
    logic                        nack;
    logic [7:0]                  rbyte;
  } beat_t;

  logic                        clk = 1'b0;
  logic                        rst_n = 1'b0;
  logic                        in_valid = 1'b0;
  logic                        in_stall;
  logic [2:0]                  in_operation = '0;
  logic [2:0]                  in_load_index = '0;
  logic [7:0]                  in_load_byte = '0;
  logic [i2cms_pkg::CNT_W-1:0] in_cmd_count = '0;
  logic [i2cms_pkg::CNT_W-1:0] in_data_count = '0;
  logic                        in_bus_busy_flag = 1'b0;
  logic                        in_ack_status_flag = 1'b0;
  logic [7:0]                  in_bus_read_byte = '0;
  logic                        out_valid;
  logic                        out_stall = 1'b0;
  logic                        out_accepted;
  logic                        out_write_strobe;
  logic [7:0]                  out_write_value;
  logic                        out_repeat_start;
  logic                        out_read_strobe;
  logic                        out_rx_store;
  logic [2:0]                  out_rx_position;
  logic [7:0]                  out_rx_value;
  logic                        out_ack_enable;
  logic                        out_master_mode;
  logic                        out_transmit_dir;
  logic                        out_busy_res;

  int   fail_count;
  int   outstanding;
  int   cycle_count = 0;
  int   sent_beats = 0;
  int   tx_idle_pct = 36;
  int   rx_idle_pct = 74;
  logic rx_hold = 1'b0;
  event rx_hold_ev;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  i2c_master_transfer_sequencer_top i_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_operation       (in_operation),
    .in_load_index      (in_load_index),
    .in_load_byte       (in_load_byte),
    .in_cmd_count       (in_cmd_count),
    .in_data_count      (in_data_count),
    .in_bus_busy_flag   (in_bus_busy_flag),
    .in_ack_status_flag (in_ack_status_flag),
    .in_bus_read_byte   (in_bus_read_byte),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_accepted       (out_accepted),
    .out_write_strobe   (out_write_strobe),
    .out_write_value    (out_write_value),
    .out_repeat_start   (out_repeat_start),
    .out_read_strobe    (out_read_strobe),
    .out_rx_store       (out_rx_store),
    .out_rx_position    (out_rx_position),
    .out_rx_value       (out_rx_value),
    .out_ack_enable     (out_ack_enable),
    .out_master_mode    (out_master_mode),
    .out_transmit_dir   (out_transmit_dir),
    .out_busy_res       (out_busy_res)
  );

  i2cms_transfer_checker i_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_operation       (in_operation),
    .in_load_index      (in_load_index),
    .in_load_byte       (in_load_byte),
    .in_cmd_count       (in_cmd_count),
    .in_data_count      (in_data_count),
    .in_bus_busy_flag   (in_bus_busy_flag),
    .in_ack_status_flag (in_ack_status_flag),
    .in_bus_read_byte   (in_bus_read_byte),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_accepted       (out_accepted),
    .out_write_strobe   (out_write_strobe),
    .out_write_value    (out_write_value),
    .out_repeat_start   (out_repeat_start),
    .out_read_strobe    (out_read_strobe),
    .out_rx_store       (out_rx_store),
    .out_rx_position    (out_rx_position),
    .out_rx_value       (out_rx_value),
    .out_ack_enable     (out_ack_enable),
    .out_master_mode    (out_master_mode),
    .out_transmit_dir   (out_transmit_dir),
    .out_busy_res       (out_busy_res),
    .fail_count         (fail_count),
    .outstanding        (outstanding)
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= rx_hold || (int'($urandom_range(99)) < rx_idle_pct);
    end
  end

  initial forever begin
    @(rx_hold_ev);
    rx_hold <= 1'b1;
    repeat (RX_HOLD_CYCLES) @(posedge clk);
    rx_hold <= 1'b0;
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) @(posedge clk);
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic beat_t rand_beat();
    beat_t b;
    b.op    = 3'($urandom_range(7));
    b.idx   = 3'($urandom_range(7));
    b.lbyte = 8'($urandom_range(255));
    b.cc    = i2cms_pkg::CNT_W'($urandom_range(15));
    b.dc    = i2cms_pkg::CNT_W'($urandom_range(15));
    b.bb    = 1'($urandom_range(1));
    b.nack  = 1'($urandom_range(1));
    b.rbyte = 8'($urandom_range(255));
    return b;
  endfunction

  function automatic beat_t load_beat(logic [2:0] op, logic [2:0] idx, logic [7:0] lbyte);
    beat_t b;
    b       = rand_beat();
    b.op    = op;
    b.idx   = idx;
    b.lbyte = lbyte;
    return b;
  endfunction

  function automatic beat_t start_beat(logic [2:0] op, logic [i2cms_pkg::CNT_W-1:0] cc,
                                       logic [i2cms_pkg::CNT_W-1:0] dc, logic bb);
    beat_t b;
    b    = rand_beat();
    b.op = op;
    b.cc = cc;
    b.dc = dc;
    b.bb = bb;
    return b;
  endfunction

  function automatic beat_t irq_beat(logic nack, logic [7:0] rbyte);
    beat_t b;
    b       = rand_beat();
    b.op    = i2cms_pkg::OP_IRQ;
    b.nack  = nack;
    b.rbyte = rbyte;
    return b;
  endfunction

  // entered at the edge where the previous beat went in
  task automatic send_beat(input beat_t b);
    if (int'($urandom_range(99)) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while (int'($urandom_range(99)) < tx_idle_pct) @(posedge clk);
    end
    in_valid           <= 1'b1;
    in_operation       <= b.op;
    in_load_index      <= b.idx;
    in_load_byte       <= b.lbyte;
    in_cmd_count       <= b.cc;
    in_data_count      <= b.dc;
    in_bus_busy_flag   <= b.bb;
    in_ack_status_flag <= b.nack;
    in_bus_read_byte   <= b.rbyte;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent_beats++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  // loads, one start, then one interrupt per byte of the transfer, with stray random beats mixed in
  task automatic run_transfer();
    beat_t                       b;
    logic [i2cms_pkg::CNT_W-1:0] cc;
    logic [i2cms_pkg::CNT_W-1:0] dc;
    repeat ($urandom_range(2))
      send_beat(load_beat(3'($urandom_range(1)), 3'($urandom_range(7)),
                          8'($urandom_range(255))));
    cc = ($urandom_range(9) == 0) ? i2cms_pkg::CNT_W'($urandom_range(15))
                                  : i2cms_pkg::CNT_W'($urandom_range(8));
    dc = ($urandom_range(9) == 0) ? i2cms_pkg::CNT_W'($urandom_range(15))
                                  : i2cms_pkg::CNT_W'($urandom_range(8, 1));
    b  = start_beat($urandom_range(1) ? i2cms_pkg::OP_START_WR : i2cms_pkg::OP_START_RD,
                    cc, dc, $urandom_range(19) == 0);
    send_beat(b);
    repeat (int'(cc) + int'(dc)) begin
      if ($urandom_range(19) == 0) send_beat(rand_beat());
      send_beat(irq_beat($urandom_range(24) == 0, 8'($urandom_range(255))));
    end
  endtask

  initial begin
    beat_t b;
    int    phase;
    phase = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // fill both stores so no transfer reads an unloaded entry
    for (int i = 0; i < i2cms_pkg::CMD_DEPTH; i++)
      send_beat(load_beat(i2cms_pkg::OP_LOAD_CMD, 3'(i),
                          (i == 0) ? 8'h00 : (i == 1) ? 8'hFF : 8'($urandom_range(255))));
    for (int i = 0; i < i2cms_pkg::DATA_DEPTH; i++)
      send_beat(load_beat(i2cms_pkg::OP_LOAD_TX, 3'(i),
                          (i == 0) ? 8'hFF : (i == 1) ? 8'h00 : 8'($urandom_range(255))));

    b    = rand_beat();
    b.op = 3'd7;
    send_beat(b);
    send_beat(irq_beat(1'b0, 8'hFF));
    send_beat(start_beat(i2cms_pkg::OP_START_WR, 4'd3, 4'd0, 1'b0));
    send_beat(start_beat(i2cms_pkg::OP_START_RD, 4'd2, 4'd2, 1'b1));
    send_beat(start_beat(i2cms_pkg::OP_START_RD, 4'd0, 4'd1, 1'b0));
    send_beat(irq_beat(1'b0, 8'hFF));
    send_beat(start_beat(i2cms_pkg::OP_START_RD, 4'd2, 4'd2, 1'b0));
    send_beat(start_beat(i2cms_pkg::OP_START_WR, 4'd1, 4'd1, 1'b0));
    send_beat(irq_beat(1'b0, 8'h00));
    send_beat(irq_beat(1'b0, 8'hFF));
    send_beat(irq_beat(1'b0, 8'h00));
    send_beat(irq_beat(1'b0, 8'hA5));

    while (sent_beats < TARGET_BEATS) begin
      if (phase == 0 && sent_beats >= TARGET_BEATS / 3) begin
        drain();
        tx_idle_pct = 74;
        rx_idle_pct <= 36;
        phase = 1;
      end else if (phase == 1 && sent_beats >= 2 * TARGET_BEATS / 3) begin
        drain();
        tx_idle_pct = 0;
        rx_idle_pct <= 0;
        phase = 2;
        -> rx_hold_ev;
      end
      if ($urandom_range(99) < 80) run_transfer();
      else send_beat(rand_beat());
    end

    drain();
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
